FILE: hdl/cswd_pkg.sv
// ============================================================================
// Contact sensor watchdog package
// Shared types, register indexes and reset values of the contact sensor
// stuck and blind watchdog.
// ============================================================================
package cswd_pkg;

    localparam int NUM_SENSORS_DEF = 2;

    localparam logic [31:0] STUCK_LIMIT_RST  = 32'd1200000;
    localparam logic [31:0] BLIND_LIMIT_RST  = 32'd21600000;
    localparam logic [31:0] PRESENCE_WIN_RST = 32'd3000;
    localparam logic [15:0] VETO_MAX         = 16'hFFFF;
    localparam logic [31:0] SILENCE_MAX      = 32'hFFFF_FFFF;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_BLIND   = 2'd2,
        ST_STUCK   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_STUCK_LIMIT  = 2'd0,
        CFG_BLIND_LIMIT  = 2'd1,
        CFG_PRESENCE_WIN = 2'd2
    } t_cfg_idx;

endpackage

FILE: hdl/contact_sensor_stuck_blind_watchdog_core.sv
// ============================================================================
// Contact sensor stuck and blind watchdog
// Tracks rising edges, barrier-up silence and sustained high levels of the
// presence contacts, raises blind and stuck alarms and counts barrier drops
// that happened while presence was seen.
// ============================================================================
// An item waits in the input register until its result is registered.
// Throughput: one item per cycle unless the output stalls; the input and
// result registers are the only stages, with per-sensor compare logic between.
// Reset: synchronous, active low; all sensors start unknown, the veto count is
// zero and the limit registers take their default values.
module contact_sensor_stuck_blind_watchdog_core #(
    parameter int NUM_SENSORS = cswd_pkg::NUM_SENSORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_ms,
    input  logic        i_boom_up,
    input  logic [1:0]  i_sensor_levels,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_demand_mask,
    output logic [1:0]  o_blind_alarm_mask,
    output logic [1:0]  o_stuck_alarm_mask,
    output logic [1:0]  o_recovered_mask,
    output logic        o_veto_event,
    output logic [15:0] o_veto_total,
    output logic [1:0]  o_worst_status,
    output logic [3:0]  o_status_pair
);

    logic [31:0] r_stuck_limit;
    logic [31:0] r_blind_limit;
    logic [31:0] r_presence_win;

    logic        r_in_valid;
    logic        r_in_kind;
    logic [31:0] r_in_now;
    logic        r_in_boom;
    logic [1:0]  r_in_levels;

    logic                r_prev_level   [NUM_SENSORS];
    cswd_pkg::t_status   r_status       [NUM_SENSORS];
    logic [31:0]         r_high_since   [NUM_SENSORS];
    logic [31:0]         r_silence      [NUM_SENSORS];
    logic [31:0]         r_last_edge    [NUM_SENSORS];
    logic                r_had_edge     [NUM_SENSORS];
    logic [31:0]         r_prev_tick;
    logic                r_prev_boom;
    logic [15:0]         r_veto_count;

    logic                n_prev_level   [NUM_SENSORS];
    cswd_pkg::t_status   n_status       [NUM_SENSORS];
    logic [31:0]         n_high_since   [NUM_SENSORS];
    logic [31:0]         n_silence      [NUM_SENSORS];
    logic [31:0]         n_last_edge    [NUM_SENSORS];
    logic                n_had_edge     [NUM_SENSORS];
    logic [31:0]         n_prev_tick;
    logic                n_prev_boom;
    logic [15:0]         n_veto_count;

    logic [NUM_SENSORS+1:0]   w_levels_ext;
    cswd_pkg::t_status        w_status_ext [NUM_SENSORS+2];
    logic [NUM_SENSORS-1:0]   w_demand;
    logic [NUM_SENSORS-1:0]   w_blind;
    logic [NUM_SENSORS-1:0]   w_stuck;
    logic [NUM_SENSORS-1:0]   w_recov;
    logic                     w_veto;
    logic [1:0]               w_worst;
    logic                     w_advance;
    logic                     w_in_accept;

    logic        r_out_valid;
    logic [1:0]  r_demand;
    logic [1:0]  r_blind;
    logic [1:0]  r_stuck;
    logic [1:0]  r_recov;
    logic        r_veto;
    logic [15:0] r_veto_total;
    logic [1:0]  r_worst;
    logic [3:0]  r_pair;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_levels_ext = {NUM_SENSORS'(0), r_in_levels};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuck_limit  <= cswd_pkg::STUCK_LIMIT_RST;
            r_blind_limit  <= cswd_pkg::BLIND_LIMIT_RST;
            r_presence_win <= cswd_pkg::PRESENCE_WIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cswd_pkg::CFG_STUCK_LIMIT:  r_stuck_limit  <= i_cfg_wdata;
                cswd_pkg::CFG_BLIND_LIMIT:  r_blind_limit  <= i_cfg_wdata;
                cswd_pkg::CFG_PRESENCE_WIN: r_presence_win <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_kind   <= i_kind;
            r_in_now    <= i_now_ms;
            r_in_boom   <= i_boom_up;
            r_in_levels <= i_sensor_levels;
        end
    end

    always_comb begin
        logic [31:0] v_dt;
        logic [32:0] v_sum;
        logic        v_presence;
        logic        v_lv;
        v_dt         = r_in_now - r_prev_tick;
        v_sum        = '0;
        v_presence   = 1'b0;
        v_lv         = 1'b0;
        n_prev_tick  = r_prev_tick;
        n_prev_boom  = r_prev_boom;
        n_veto_count = r_veto_count;
        w_demand     = '0;
        w_blind      = '0;
        w_stuck      = '0;
        w_recov      = '0;
        w_veto       = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            n_prev_level[i] = r_prev_level[i];
            n_status[i]     = r_status[i];
            n_high_since[i] = r_high_since[i];
            n_silence[i]    = r_silence[i];
            n_last_edge[i]  = r_last_edge[i];
            n_had_edge[i]   = r_had_edge[i];
            if (r_prev_level[i] || (r_had_edge[i]
                    && (r_in_now - r_last_edge[i]) <= r_presence_win)) begin
                v_presence = 1'b1;
            end
        end

        if (r_in_kind == cswd_pkg::KIND_SEED) begin
            n_prev_tick = r_in_now;
            n_prev_boom = r_in_boom;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                n_prev_level[i] = w_levels_ext[i];
                n_high_since[i] = r_in_now;
            end
        end else begin
            n_prev_tick = r_in_now;
            n_prev_boom = r_in_boom;
            if (r_prev_boom && !r_in_boom && v_presence) begin
                w_veto = 1'b1;
                if (r_veto_count != cswd_pkg::VETO_MAX) begin
                    n_veto_count = r_veto_count + 16'd1;
                end
            end
            for (int i = 0; i < NUM_SENSORS; i++) begin
                v_lv = w_levels_ext[i];
                if (r_in_boom) begin
                    v_sum = {1'b0, r_silence[i]} + {1'b0, v_dt};
                    n_silence[i] = v_sum[32] ? cswd_pkg::SILENCE_MAX : v_sum[31:0];
                    if (n_silence[i] >= r_blind_limit
                            && r_status[i] != cswd_pkg::ST_BLIND
                            && r_status[i] != cswd_pkg::ST_STUCK) begin
                        n_status[i] = cswd_pkg::ST_BLIND;
                        w_blind[i]  = 1'b1;
                    end
                end
                if (v_lv && !r_prev_level[i]) begin
                    w_demand[i]     = 1'b1;
                    n_last_edge[i]  = r_in_now;
                    n_had_edge[i]   = 1'b1;
                    n_high_since[i] = r_in_now;
                    n_silence[i]    = '0;
                    if (n_status[i] == cswd_pkg::ST_BLIND) begin
                        w_recov[i] = 1'b1;
                    end
                    n_status[i] = cswd_pkg::ST_OK;
                end
                if (!v_lv) begin
                    if (n_status[i] == cswd_pkg::ST_STUCK) begin
                        n_status[i] = cswd_pkg::ST_OK;
                        w_recov[i]  = 1'b1;
                    end
                end else if ((r_in_now - n_high_since[i]) >= r_stuck_limit
                        && n_status[i] != cswd_pkg::ST_STUCK) begin
                    n_status[i] = cswd_pkg::ST_STUCK;
                    w_stuck[i]  = 1'b1;
                end
                n_prev_level[i] = v_lv;
            end
        end
    end

    always_comb begin
        w_worst = 2'd0;
        for (int i = 0; i < NUM_SENSORS + 2; i++) begin
            w_status_ext[i] = cswd_pkg::ST_OK;
        end
        for (int i = 0; i < NUM_SENSORS; i++) begin
            w_status_ext[i] = n_status[i];
            if (n_status[i] > w_worst) begin
                w_worst = n_status[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_prev_level[i] <= 1'b0;
                r_status[i]     <= cswd_pkg::ST_UNKNOWN;
                r_high_since[i] <= '0;
                r_silence[i]    <= '0;
                r_last_edge[i]  <= '0;
                r_had_edge[i]   <= 1'b0;
            end
            r_prev_tick  <= '0;
            r_prev_boom  <= 1'b0;
            r_veto_count <= '0;
        end else if (w_advance) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_prev_level[i] <= n_prev_level[i];
                r_status[i]     <= n_status[i];
                r_high_since[i] <= n_high_since[i];
                r_silence[i]    <= n_silence[i];
                r_last_edge[i]  <= n_last_edge[i];
                r_had_edge[i]   <= n_had_edge[i];
            end
            r_prev_tick  <= n_prev_tick;
            r_prev_boom  <= n_prev_boom;
            r_veto_count <= n_veto_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_demand     <= 2'({NUM_SENSORS'(0), w_demand});
            r_blind      <= 2'({NUM_SENSORS'(0), w_blind});
            r_stuck      <= 2'({NUM_SENSORS'(0), w_stuck});
            r_recov      <= 2'({NUM_SENSORS'(0), w_recov});
            r_veto       <= w_veto;
            r_veto_total <= n_veto_count;
            r_worst      <= w_worst;
            r_pair       <= {w_status_ext[1], w_status_ext[0]};
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_demand_mask      = r_demand;
    assign o_blind_alarm_mask = r_blind;
    assign o_stuck_alarm_mask = r_stuck;
    assign o_recovered_mask   = r_recov;
    assign o_veto_event       = r_veto;
    assign o_veto_total       = r_veto_total;
    assign o_worst_status     = r_worst;
    assign o_status_pair      = r_pair;

endmodule

FILE: hdl/cswd_checker.sv
// ============================================================================
// Contact sensor watchdog checker
// Port-level assertions on the result channel of the watchdog core.
// ============================================================================
module cswd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_demand_mask,
    input logic [1:0]  o_stuck_alarm_mask,
    input logic        o_veto_event,
    input logic [15:0] o_veto_total,
    input logic [1:0]  o_worst_status,
    input logic [3:0]  o_status_pair
);

    // A result that waits must stay as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_demand_mask) && $stable(o_veto_total)
            && $stable(o_status_pair))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_veto_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_veto_event |-> o_veto_total != 16'd0)
        else $error("veto event with zero total");

    a_worst_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_worst_status >= o_status_pair[1:0]
            && o_worst_status >= o_status_pair[3:2])
        else $error("worst status below a sensor status");

    a_stuck_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stuck_alarm_mask[0]
            |-> o_status_pair[1:0] == cswd_pkg::ST_STUCK)
        else $error("stuck alarm without stuck status");

endmodule

bind contact_sensor_stuck_blind_watchdog_core cswd_checker u_cswd_checker (.*);

FILE: tb/tb_contact_sensor_stuck_blind_watchdog_core.sv
// ============================================================================
// Contact sensor watchdog testbench
// Drives seed and tick items into the watchdog core and checks every result
// against a cycle-free model of the edge, silence, stuck and veto logic. The
// run covers the reset limits, zero and all-ones limits, time wrap, silence
// saturation, veto counting, and random traffic under several limit settings
// and idle mixes, with a long output hold-off and mid-phase drains.
// ============================================================================
module tb_contact_sensor_stuck_blind_watchdog_core;
    import cswd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int VETO_PAIRS     = 10;

    typedef struct packed {
        logic [1:0]  demand;
        logic [1:0]  blind;
        logic [1:0]  stuck;
        logic [1:0]  recov;
        logic        veto;
        logic [15:0] veto_total;
        logic [1:0]  worst;
        logic [3:0]  pair;
    } watch_result_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_idx       = CFG_STUCK_LIMIT;
    logic [31:0] i_cfg_wdata     = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic        i_kind          = KIND_SEED;
    logic [31:0] i_now_ms        = '0;
    logic        i_boom_up       = 1'b0;
    logic [1:0]  i_sensor_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [1:0]  o_demand_mask;
    logic [1:0]  o_blind_alarm_mask;
    logic [1:0]  o_stuck_alarm_mask;
    logic [1:0]  o_recovered_mask;
    logic        o_veto_event;
    logic [15:0] o_veto_total;
    logic [1:0]  o_worst_status;
    logic [3:0]  o_status_pair;

    logic [31:0] stuck_lim_ms  = STUCK_LIMIT_RST;
    logic [31:0] blind_lim_ms  = BLIND_LIMIT_RST;
    logic [31:0] window_ms     = PRESENCE_WIN_RST;
    logic        level_q    [2] = '{1'b0, 1'b0};
    t_status     sensor_state [2] = '{ST_UNKNOWN, ST_UNKNOWN};
    logic [31:0] high_start [2] = '{32'd0, 32'd0};
    logic [31:0] quiet_ms   [2] = '{32'd0, 32'd0};
    logic [31:0] edge_ms    [2] = '{32'd0, 32'd0};
    logic        edge_seen  [2] = '{1'b0, 1'b0};
    logic [31:0] last_tick_ms = '0;
    logic        was_boom_up  = 1'b0;
    logic [15:0] veto_cnt     = '0;

    watch_result_t pending_watch_q [$];
    watch_result_t want;

    int          error_count        = 0;
    int          item_count         = 0;
    int          result_count       = 0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          hold_seq           = 0;
    int          hold_seen          = 0;
    int          hold_left          = 0;
    int          quiet_cycles       = 0;
    logic [31:0] gen_ms     = '0;
    logic        gen_boom   = 1'b0;
    logic [1:0]  gen_levels = '0;

    contact_sensor_stuck_blind_watchdog_core #(
        .NUM_SENSORS(NUM_SENSORS_DEF)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_now_ms          (i_now_ms),
        .i_boom_up         (i_boom_up),
        .i_sensor_levels   (i_sensor_levels),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_demand_mask     (o_demand_mask),
        .o_blind_alarm_mask(o_blind_alarm_mask),
        .o_stuck_alarm_mask(o_stuck_alarm_mask),
        .o_recovered_mask  (o_recovered_mask),
        .o_veto_event      (o_veto_event),
        .o_veto_total      (o_veto_total),
        .o_worst_status    (o_worst_status),
        .o_status_pair     (o_status_pair)
    );

    always #5 i_clk = ~i_clk;

    function automatic watch_result_t predict_watch(input logic kind, input logic [31:0] now,
                                                    input logic boom, input logic [1:0] levels);
        watch_result_t r;
        logic [31:0]   dt;
        logic [31:0]   elapsed;
        logic [32:0]   sum;
        logic          presence;
        logic          lv;
        r = '0;
        if (kind == KIND_SEED) begin
            last_tick_ms = now;
            was_boom_up  = boom;
            for (int s = 0; s < 2; s++) begin
                level_q[s]    = levels[s];
                high_start[s] = now;
            end
        end else begin
            dt           = now - last_tick_ms;
            last_tick_ms = now;
            if (boom) begin
                for (int s = 0; s < 2; s++) begin
                    sum         = {1'b0, quiet_ms[s]} + {1'b0, dt};
                    quiet_ms[s] = sum[32] ? SILENCE_MAX : sum[31:0];
                    if (quiet_ms[s] >= blind_lim_ms && sensor_state[s] != ST_BLIND
                        && sensor_state[s] != ST_STUCK) begin
                        sensor_state[s] = ST_BLIND;
                        r.blind[s]      = 1'b1;
                    end
                end
            end
            if (was_boom_up && !boom) begin
                presence = 1'b0;
                for (int s = 0; s < 2; s++) begin
                    elapsed = now - edge_ms[s];
                    if (level_q[s] || (edge_seen[s] && elapsed <= window_ms)) begin
                        presence = 1'b1;
                    end
                end
                if (presence) begin
                    if (veto_cnt != VETO_MAX) begin
                        veto_cnt = veto_cnt + 16'd1;
                    end
                    r.veto = 1'b1;
                end
            end
            was_boom_up = boom;
            for (int s = 0; s < 2; s++) begin
                lv = levels[s];
                if (lv && !level_q[s]) begin
                    r.demand[s]   = 1'b1;
                    edge_ms[s]    = now;
                    edge_seen[s]  = 1'b1;
                    high_start[s] = now;
                    quiet_ms[s]   = '0;
                    if (sensor_state[s] == ST_BLIND) begin
                        r.recov[s] = 1'b1;
                    end
                    sensor_state[s] = ST_OK;
                end
                elapsed = now - high_start[s];
                if (!lv) begin
                    if (sensor_state[s] == ST_STUCK) begin
                        sensor_state[s] = ST_OK;
                        r.recov[s]      = 1'b1;
                    end
                end else if (elapsed >= stuck_lim_ms && sensor_state[s] != ST_STUCK) begin
                    sensor_state[s] = ST_STUCK;
                    r.stuck[s]      = 1'b1;
                end
                level_q[s] = lv;
            end
        end
        r.veto_total = veto_cnt;
        r.worst = (sensor_state[0] > sensor_state[1]) ? sensor_state[0] : sensor_state[1];
        r.pair  = {sensor_state[1], sensor_state[0]};
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_watch_q.size() == 0) begin
                $display("%0t: result arrived with no item pending, actual veto_total %0h",
                         $time, o_veto_total);
                error_count++;
            end else begin
                want = pending_watch_q.pop_front();
                check_field("demand_mask",      want.demand,     o_demand_mask);
                check_field("blind_alarm_mask", want.blind,      o_blind_alarm_mask);
                check_field("stuck_alarm_mask", want.stuck,      o_stuck_alarm_mask);
                check_field("recovered_mask",   want.recov,      o_recovered_mask);
                check_field("veto_event",       want.veto,       o_veto_event);
                check_field("veto_total",       want.veto_total, o_veto_total);
                check_field("worst_status",     want.worst,      o_worst_status);
                check_field("status_pair",      want.pair,       o_status_pair);
                result_count++;
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] now, input logic boom,
                             input logic [1:0] levels);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_now_ms        <= now;
        i_boom_up       <= boom;
        i_sensor_levels <= levels;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_watch_q.push_back(predict_watch(kind, now, boom, levels));
        item_count++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_watch_q.size() != 0);
    endtask

    task automatic set_limits(input logic [31:0] stuck_v, input logic [31:0] blind_v,
                              input logic [31:0] win_v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_STUCK_LIMIT;
        i_cfg_wdata <= stuck_v;
        @(posedge i_clk);
        stuck_lim_ms = stuck_v;
        i_cfg_idx   <= CFG_BLIND_LIMIT;
        i_cfg_wdata <= blind_v;
        @(posedge i_clk);
        blind_lim_ms = blind_v;
        i_cfg_idx   <= CFG_PRESENCE_WIN;
        i_cfg_wdata <= win_v;
        @(posedge i_clk);
        window_ms = win_v;
        i_cfg_we  <= 1'b0;
    endtask

    task automatic test_default_limits();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(KIND_TICK, 32'd5,        1'b0, 2'b00);
        send_item(KIND_SEED, 32'd0,        1'b1, 2'b11);
        send_item(KIND_TICK, 32'd1199999,  1'b1, 2'b11);
        send_item(KIND_TICK, 32'd1200000,  1'b1, 2'b11);
        send_item(KIND_TICK, 32'd21600000, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd21600001, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd21600002, 1'b1, 2'b01);
        send_item(KIND_TICK, 32'd21600003, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd21603002, 1'b0, 2'b00);
        send_item(KIND_TICK, 32'd21603003, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd21606003, 1'b0, 2'b00);
    endtask

    task automatic test_zero_limits();
        set_limits(32'd0, 32'd0, 32'd0);
        send_item(KIND_SEED, 32'd100, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd100, 1'b1, 2'b10);
        send_item(KIND_TICK, 32'd101, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'd102, 1'b1, 2'b10);
        send_item(KIND_TICK, 32'd103, 1'b0, 2'b10);
    endtask

    task automatic test_max_limits_and_wrap();
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_SEED, 32'hFFFF_FFF0, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'h0000_0010, 1'b1, 2'b01);
        send_item(KIND_TICK, 32'h0000_000F, 1'b1, 2'b01);
        send_item(KIND_TICK, 32'h0000_0020, 1'b0, 2'b00);
        send_item(KIND_TICK, 32'h0000_0021, 1'b1, 2'b00);
        send_item(KIND_TICK, 32'h0000_0030, 1'b0, 2'b00);
    endtask

    task automatic run_random_phase(input logic [31:0] stuck_v, input logic [31:0] blind_v,
                                    input logic [31:0] win_v, input int step_max,
                                    input int n_items, input int idle_pct, input int stall_p,
                                    input bit long_hold);
        logic kind;
        int   pick;
        set_limits(stuck_v, blind_v, win_v);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_p;
        send_item(KIND_SEED, gen_ms, gen_boom, gen_levels);
        for (int k = 0; k < n_items; k++) begin
            if (long_hold && k == n_items / 4) begin
                hold_seq <= hold_seq + 1;
            end
            if (k == n_items / 2) begin
                wait_drain();
            end
            pick = $urandom_range(99, 0);
            if (pick < 80) begin
                gen_ms = gen_ms + $urandom_range(step_max, 0);
            end else if (pick >= 88 && pick < 95) begin
                gen_ms = $urandom();
            end else if (pick >= 95) begin
                gen_ms = 32'hFFFF_FFFF - $urandom_range(40, 0);
            end
            if ($urandom_range(99, 0) < 15) begin
                gen_boom = ~gen_boom;
            end
            if ($urandom_range(99, 0) < 5) begin
                gen_levels = 2'($urandom_range(3, 0));
            end else begin
                for (int b = 0; b < 2; b++) begin
                    if ($urandom_range(99, 0) < 12) begin
                        gen_levels[b] = ~gen_levels[b];
                    end
                end
            end
            kind = ($urandom_range(99, 0) < 4) ? KIND_SEED : KIND_TICK;
            send_item(kind, gen_ms, gen_boom, gen_levels);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(32'd40, 32'd120, 32'd15, 8, 140, 0, 0, 1'b1);
        run_random_phase(32'd1, 32'd1, 32'd0, 3, 140, 58, 0, 1'b0);
        run_random_phase($urandom_range(200, 20), $urandom_range(400, 50),
                         $urandom_range(50, 0), 20, 140, 0, 58, 1'b0);
        run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5000, 140, 21, 21, 1'b0);
        run_random_phase(32'd300, 32'd25, 32'd100, 10, 140, 0, 0, 1'b0);
        run_random_phase($urandom_range(60, 1), $urandom_range(60, 1),
                         $urandom_range(20, 0), 6, 140, 58, 0, 1'b0);
        run_random_phase($urandom_range(2000, 100), $urandom_range(2000, 100),
                         $urandom_range(500, 0), 200, 140, 0, 58, 1'b0);
        run_random_phase(STUCK_LIMIT_RST, BLIND_LIMIT_RST, PRESENCE_WIN_RST, 400000, 140,
                         21, 21, 1'b0);
    endtask

    task automatic test_veto_count();
        set_limits(STUCK_LIMIT_RST, BLIND_LIMIT_RST, 32'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(KIND_SEED, 32'd0, 1'b0, 2'b01);
        for (int k = 0; k < VETO_PAIRS; k++) begin
            send_item(KIND_TICK, 32'(2 * k + 1), 1'b1, 2'b01);
            send_item(KIND_TICK, 32'(2 * k + 2), 1'b0, 2'b01);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_limits();
        test_zero_limits();
        test_max_limits_and_wrap();
        test_random_traffic();
        test_veto_count();
        wait_drain();
        repeat (6) @(posedge i_clk);
        $display("Checked %0d items and %0d results with %0d errors.",
                 item_count, result_count, error_count);
        $display("Covered reset, zero, all-ones and random limits, time wrap, idle mixes, a long");
        $display("output hold-off and veto counting over repeated barrier drops.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
